### rtl/keyed_compact_table_assert.svh
// assertion macros for the keyed compact table
// no dependencies; taken in by the files that carry assertions
`ifndef KEYED_COMPACT_TABLE_ASSERT_SVH
`define KEYED_COMPACT_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked at every rising edge out of reset
`define KCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("keyed_compact_table: assertion failed");
// next-cycle implication
`define KCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("keyed_compact_table: assertion failed");
`else
`define KCT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KCT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/kct_pkg.sv
// shared types and codes for the keyed compact table
// no dependencies
package kct_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam int CMD_W   = 3;
    localparam int ROOM_W  = 16;
    localparam int PHONE_W = 16;
    localparam int TAG_W   = 64;
    localparam int EIDX_W  = 8;
    localparam int STAT_W  = 2;
    localparam int FIDX_W  = 8;
    localparam int USED_W  = 9;
    localparam int ENTRY_W = ROOM_W + PHONE_W + TAG_W;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UPSERT    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_ROOM  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_INDEX = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [ROOM_W-1:0]  room;
        logic [PHONE_W-1:0] phone;
        logic [TAG_W-1:0]   name_tag;
    } t_entry;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ROOM_W-1:0]  room;
        logic [PHONE_W-1:0] phone;
        logic [TAG_W-1:0]   name_tag;
        logic [EIDX_W-1:0]  entry_index;
    } t_item;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [FIDX_W-1:0]  found_index;
        t_entry             data;
        logic [USED_W-1:0]  used_entries;
    } t_result;

endpackage

### rtl/kct_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module kct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/kct_seq.sv
// command sequencer: entry count, linear scan compare, swap-with-last move
// depends on kct_pkg and keyed_compact_table_assert.svh; drives one kct_ram
`include "keyed_compact_table_assert.svh"
module kct_seq #(
    parameter int CAPACITY = kct_pkg::CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  kct_pkg::t_item              i_item,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output kct_pkg::t_result            o_res,
    output logic                        o_ram_we,
    output logic [$clog2(CAPACITY)-1:0] o_ram_waddr,
    output logic [kct_pkg::ENTRY_W-1:0] o_ram_wdata,
    output logic                        o_ram_re,
    output logic [$clog2(CAPACITY)-1:0] o_ram_raddr,
    input  logic [kct_pkg::ENTRY_W-1:0] i_ram_rdata
);
    import kct_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > EIDX_W) ? CW : EIDX_W;
    localparam int FW = (AW > FIDX_W) ? AW : FIDX_W;
    localparam int UW = (CW > USED_W) ? CW : USED_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_MVRD   = 3'd2;
    localparam logic [2:0] S_MVWR   = 3'd3;
    localparam logic [2:0] S_RDWAIT = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]        r_state,   n_state;
    logic [CW-1:0]     r_count,   n_count;
    logic [CW-1:0]     r_ptr,     n_ptr;
    logic              r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]     r_cmp_idx, n_cmp_idx;
    logic [AW-1:0]     r_hole,    n_hole;
    t_item             r_item,    n_item;
    logic [STAT_W-1:0] r_status,  n_status;
    logic [AW-1:0]     r_fidx,    n_fidx;
    t_entry            r_data,    n_data;

    t_entry        rd_entry;
    t_entry        wr_entry;
    logic [EW-1:0] eidx_ext;
    logic [EW-1:0] cnt_ext;
    logic [AW-1:0] eidx_addr;
    logic [CW-1:0] count_m1;
    logic [FW-1:0] fidx_ext;
    logic [UW-1:0] used_ext;
    logic          hit;
    logic          issue;

    assign rd_entry  = t_entry'(i_ram_rdata);
    assign wr_entry  = '{room: r_item.room, phone: r_item.phone, name_tag: r_item.name_tag};
    assign eidx_ext  = EW'(i_item.entry_index);
    assign cnt_ext   = EW'(r_count);
    assign eidx_addr = eidx_ext[AW-1:0];
    assign count_m1  = r_count - CW'(1);
    assign hit       = r_cmp_vld && (rd_entry.room == r_item.room);
    assign issue     = r_ptr < r_count;
    assign fidx_ext  = FW'(r_fidx);
    assign used_ext  = UW'(r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_idx   = r_cmp_idx;
        n_hole      = r_hole;
        n_item      = r_item;
        n_status    = r_status;
        n_fidx      = r_fidx;
        n_data      = r_data;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = '0;
        o_ram_wdata = '0;
        o_ram_re    = 1'b0;
        o_ram_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_item    = i_item;
                    n_status  = ST_OK;
                    n_fidx    = '0;
                    n_data    = '0;
                    n_ptr     = '0;
                    n_cmp_vld = 1'b0;
                    unique case (i_item.cmd)
                        CMD_LOOKUP, CMD_UPSERT, CMD_DEL_ROOM: begin
                            n_state = S_SEARCH;
                        end
                        CMD_DEL_INDEX: begin
                            if (eidx_ext < cnt_ext) begin
                                n_fidx  = eidx_addr;
                                n_hole  = eidx_addr;
                                n_count = count_m1;
                                // the last entry fills the hole unless it is the hole
                                n_state = (CW'(eidx_addr) != count_m1) ? S_MVRD : S_DONE;
                            end else begin
                                n_status = ST_RANGE;
                                n_state  = S_DONE;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                            n_state = S_DONE;
                        end
                        CMD_READ: begin
                            if (eidx_ext < cnt_ext) begin
                                n_fidx      = eidx_addr;
                                o_ram_re    = 1'b1;
                                o_ram_raddr = eidx_addr;
                                n_state     = S_RDWAIT;
                            end else begin
                                n_status = ST_RANGE;
                                n_state  = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_SEARCH: begin
                if (hit) begin
                    n_cmp_vld = 1'b0;
                    n_fidx    = r_cmp_idx;
                    n_state   = S_DONE;
                    unique case (r_item.cmd)
                        CMD_LOOKUP: begin
                            n_data = rd_entry;
                        end
                        CMD_UPSERT: begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_cmp_idx;
                            o_ram_wdata = wr_entry;
                        end
                        CMD_DEL_ROOM: begin
                            n_hole  = r_cmp_idx;
                            n_count = count_m1;
                            if (CW'(r_cmp_idx) != count_m1) begin
                                n_state = S_MVRD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end else if (issue) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = r_ptr[AW-1:0];
                    n_ptr       = r_ptr + CW'(1);
                    n_cmp_vld   = 1'b1;
                    n_cmp_idx   = r_ptr[AW-1:0];
                end else if (!r_cmp_vld) begin
                    // scan exhausted without a match
                    n_state = S_DONE;
                    if (r_item.cmd == CMD_UPSERT) begin
                        if (r_count < CW'(CAPACITY)) begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_count[AW-1:0];
                            o_ram_wdata = wr_entry;
                            n_fidx      = r_count[AW-1:0];
                            n_count     = r_count + CW'(1);
                        end else begin
                            n_status = ST_FULL;
                        end
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end else begin
                    n_cmp_vld = 1'b0;
                end
            end

            S_MVRD: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = r_count[AW-1:0];
                n_state     = S_MVWR;
            end

            S_MVWR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_hole;
                o_ram_wdata = i_ram_rdata;
                n_state     = S_DONE;
            end

            S_RDWAIT: begin
                n_data  = rd_entry;
                n_state = S_DONE;
            end

            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = '{status:       r_status,
                     found_index:  fidx_ext[FIDX_W-1:0],
                     data:         r_data,
                     used_entries: used_ext[USED_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ptr     <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ptr     <= n_ptr;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_hole    <= n_hole;
        r_item    <= n_item;
        r_status  <= n_status;
        r_fidx    <= n_fidx;
        r_data    <= n_data;
    end

    `KCT_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `KCT_ASSERT_IMP(a_write_state, i_clk, i_rst_n, o_ram_we, (r_state == S_SEARCH || r_state == S_MVWR))
    `KCT_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, (r_state == S_IDLE && i_valid), r_state != S_IDLE)
    `KCT_ASSERT_IMP(a_hole_valid, i_clk, i_rst_n, r_state == S_MVWR, CW'(r_hole) < r_count)

endmodule

### rtl/keyed_compact_table.sv
// top level of the keyed compact table: entry memory, command sequencer, result register
// depends on kct_pkg, kct_ram and kct_seq
//
// dense table of up to CAPACITY entries (room, phone, 64-bit name tag) held in one
// memory, 96 bits wide; entries below the used count are valid and packed from index 0.
// each accepted item gives exactly one result item. lookup, upsert and delete by room
// scan the valid entries one per cycle through the single read port of the memory and
// stop at the first match; deleting an entry that is not the last one then moves the
// last entry into the hole, reading it and writing it back. read by index reads the one
// entry, delete by index moves the last entry into the hole unless it is the last one.
// one item is worked on at a time and o_ready is low meanwhile; a finished result waits
// in the output register, so the next item can be taken while it is still unclaimed. the
// memory needs no clearing pass after reset: entries above the count are never read.
module keyed_compact_table #(
    parameter int CAPACITY = kct_pkg::CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [kct_pkg::CMD_W-1:0]   i_cmd,
    input  logic [kct_pkg::ROOM_W-1:0]  i_room,
    input  logic [kct_pkg::PHONE_W-1:0] i_phone,
    input  logic [kct_pkg::TAG_W-1:0]   i_name_tag,
    input  logic [kct_pkg::EIDX_W-1:0]  i_entry_index,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [kct_pkg::STAT_W-1:0]  o_status,
    output logic [kct_pkg::FIDX_W-1:0]  o_found_index,
    output logic [kct_pkg::ROOM_W-1:0]  o_out_room,
    output logic [kct_pkg::PHONE_W-1:0] o_out_phone,
    output logic [kct_pkg::TAG_W-1:0]   o_out_name_tag,
    output logic [kct_pkg::USED_W-1:0]  o_used_entries
);
    import kct_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    t_item          item;
    t_result        res;
    logic           res_valid;
    logic           res_ready;

    // memory port between sequencer and entry store
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // result register, parts the sequencer from the output handshake
    logic    r_out_valid;
    t_result r_out;

    assign item = '{cmd: i_cmd, room: i_room, phone: i_phone,
                    name_tag: i_name_tag, entry_index: i_entry_index};

    kct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    kct_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // the register takes a new result when empty or being drained this cycle
    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_found_index  = r_out.found_index;
    assign o_out_room     = r_out.data.room;
    assign o_out_phone    = r_out.data.phone;
    assign o_out_name_tag = r_out.data.name_tag;
    assign o_used_entries = r_out.used_entries;

endmodule

### tb/tb_keyed_compact_table.sv
// self-checking testbench for the keyed compact table: directed and random command items
// depends on kct_pkg and keyed_compact_table; expected results come from a table kept here
module tb_keyed_compact_table;
    import kct_pkg::*;

    localparam int CAP = CAPACITY_DEF;

    // spare command codes, the block ignores them
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam int NO_HIT         = -1;
    localparam int POOL_N         = 26;
    localparam int TARGET_ITEMS   = 1750;
    localparam int SEND_IDLE      = 22;
    localparam int RECV_IDLE      = 56;
    localparam int HOLD_AT        = 100;
    localparam int HOLD_CYCLES    = 600;
    localparam int DRAIN_CYCLES   = 300;
    localparam int TIMEOUT_CYCLES = 3000000;

    logic  i_clk     = 1'b0;
    logic  rst_n     = 1'b0;
    logic  drv_valid = 1'b0;
    logic  rcv_ready = 1'b0;
    t_item cur_item  = '0;

    logic                o_ready;
    logic                o_valid;
    logic [STAT_W-1:0]   o_status;
    logic [FIDX_W-1:0]   o_found_index;
    logic [ROOM_W-1:0]   o_out_room;
    logic [PHONE_W-1:0]  o_out_phone;
    logic [TAG_W-1:0]    o_out_name_tag;
    logic [USED_W-1:0]   o_used_entries;

    // predicted table contents, only entries below tbl_count are ever read
    logic [ROOM_W-1:0]   tbl_room  [CAP];
    logic [PHONE_W-1:0]  tbl_phone [CAP];
    logic [TAG_W-1:0]    tbl_tag   [CAP];
    int                  tbl_count = 0;

    t_item               pending_q [$];
    t_result             expected_q[$];
    logic [ROOM_W-1:0]   room_pool [POOL_N];

    int items_taken = 0;
    int n_total     = 0;
    int n_items     = 0;
    int err_count   = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    keyed_compact_table u_top (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_valid        (drv_valid),
        .o_ready        (o_ready),
        .i_cmd          (cur_item.cmd),
        .i_room         (cur_item.room),
        .i_phone        (cur_item.phone),
        .i_name_tag     (cur_item.name_tag),
        .i_entry_index  (cur_item.entry_index),
        .o_valid        (o_valid),
        .i_ready        (rcv_ready),
        .o_status       (o_status),
        .o_found_index  (o_found_index),
        .o_out_room     (o_out_room),
        .o_out_phone    (o_out_phone),
        .o_out_name_tag (o_out_name_tag),
        .o_used_entries (o_used_entries)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // table prediction
    // ------------------------------------------------------------------

    // close the hole by moving the last valid entry into it
    task automatic table_remove(input int idx);
        tbl_count = tbl_count - 1;
        if (idx != tbl_count) begin
            tbl_room[idx]  = tbl_room[tbl_count];
            tbl_phone[idx] = tbl_phone[tbl_count];
            tbl_tag[idx]   = tbl_tag[tbl_count];
        end
    endtask

    // apply one accepted item to the predicted table and work out its result
    task automatic table_apply(input t_item it, output t_result res);
        int hit;
        hit = NO_HIT;
        res = '0;
        res.status = ST_OK;
        // first-match linear search over the valid entries
        if (it.cmd == CMD_LOOKUP || it.cmd == CMD_UPSERT || it.cmd == CMD_DEL_ROOM) begin
            for (int i = 0; i < tbl_count; i++) begin
                if (hit == NO_HIT && tbl_room[i] == it.room) begin
                    hit = i;
                end
            end
        end
        case (it.cmd)
            CMD_LOOKUP: begin
                if (hit == NO_HIT) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    res.found_index   = 8'(hit);
                    res.data.room     = tbl_room[hit];
                    res.data.phone    = tbl_phone[hit];
                    res.data.name_tag = tbl_tag[hit];
                end
            end
            CMD_UPSERT: begin
                // overwrite a match, else append while there is room
                if (hit == NO_HIT && tbl_count < CAP) begin
                    hit = tbl_count;
                    tbl_count = tbl_count + 1;
                end else if (hit == NO_HIT) begin
                    res.status = ST_FULL;
                end
                if (hit != NO_HIT) begin
                    tbl_room[hit]   = it.room;
                    tbl_phone[hit]  = it.phone;
                    tbl_tag[hit]    = it.name_tag;
                    res.found_index = 8'(hit);
                end
            end
            CMD_DEL_ROOM: begin
                if (hit == NO_HIT) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    res.found_index = 8'(hit);
                    table_remove(hit);
                end
            end
            CMD_DEL_INDEX: begin
                if (int'(it.entry_index) < tbl_count) begin
                    res.found_index = it.entry_index;
                    table_remove(int'(it.entry_index));
                end else begin
                    res.status = ST_RANGE;
                end
            end
            CMD_CLEAR: begin
                tbl_count = 0;
            end
            CMD_READ: begin
                if (int'(it.entry_index) < tbl_count) begin
                    res.found_index   = it.entry_index;
                    res.data.room     = tbl_room[it.entry_index];
                    res.data.phone    = tbl_phone[it.entry_index];
                    res.data.name_tag = tbl_tag[it.entry_index];
                end else begin
                    res.status = ST_RANGE;
                end
            end
            default: begin
                // spare codes leave the table alone
            end
        endcase
        res.used_entries = USED_W'(tbl_count);
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_item(input logic [CMD_W-1:0] c, input logic [ROOM_W-1:0] rm,
                             input logic [PHONE_W-1:0] ph, input logic [TAG_W-1:0] tg,
                             input logic [EIDX_W-1:0] ix);
        t_item it;
        it.cmd         = c;
        it.room        = rm;
        it.phone       = ph;
        it.name_tag    = tg;
        it.entry_index = ix;
        pending_q.push_back(it);
        // ignored items do not count towards n_items and the target item count
        if (c <= CMD_READ) begin
            n_items++;
        end
    endtask

    // mostly rooms from a small pool so that hits and overwrites are common
    function automatic logic [ROOM_W-1:0] pool_room();
        if ($urandom_range(0, 9) == 0) begin
            return ROOM_W'($urandom);
        end
        return room_pool[$urandom_range(0, POOL_N - 1)];
    endfunction

    // mostly small indices from 0 to 31, sometimes the full range
    function automatic logic [EIDX_W-1:0] pick_index();
        if ($urandom_range(0, 9) < 7) begin
            return EIDX_W'($urandom_range(0, 31));
        end
        return EIDX_W'($urandom);
    endfunction

    task automatic push_rand(input logic [CMD_W-1:0] c, input logic [ROOM_W-1:0] rm);
        push_item(c, rm, PHONE_W'($urandom), {$urandom, $urandom}, pick_index());
    endtask

    // random mix of every command over the room pool
    task automatic mixed_burst(input int len);
        int pick;
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                push_rand(CMD_UPSERT, pool_room());
            end else if (pick < 55) begin
                push_rand(CMD_LOOKUP, pool_room());
            end else if (pick < 65) begin
                push_rand(CMD_DEL_ROOM, pool_room());
            end else if (pick < 75) begin
                push_rand(CMD_DEL_INDEX, pool_room());
            end else if (pick < 90) begin
                push_rand(CMD_READ, pool_room());
            end else if (pick < 92) begin
                push_rand(CMD_CLEAR, pool_room());
            end else if (pick < 95) begin
                push_item(pick[0] ? CMD_SPARE_LO : CMD_SPARE_HI, ROOM_W'($urandom),
                          PHONE_W'($urandom), {$urandom, $urandom}, EIDX_W'($urandom));
            end else begin
                // rooms off the pool, nearly always misses or fresh appends
                push_rand(pick[0] ? CMD_UPSERT : CMD_LOOKUP, ROOM_W'($urandom));
            end
        end
    endtask

    // fill the table to capacity with distinct rooms, then work on it while full
    task automatic fill_burst();
        logic [ROOM_W-1:0] base;
        logic [ROOM_W-1:0] stride;
        base   = ROOM_W'($urandom);
        stride = ROOM_W'($urandom) | ROOM_W'(1);   // odd stride keeps rooms distinct
        push_rand(CMD_CLEAR, base);
        for (int k = 0; k < CAP; k++) begin
            push_rand(CMD_UPSERT, ROOM_W'(base + k * stride));
        end
        // new rooms into a full table
        for (int k = 0; k < 3; k++) begin
            push_rand(CMD_UPSERT, ROOM_W'(base + (CAP + k) * stride));
        end
        push_rand(CMD_UPSERT, base);                                   // overwrite while full
        push_rand(CMD_LOOKUP, ROOM_W'(base + (CAP - 1) * stride));     // hit at the far end
        push_rand(CMD_LOOKUP, ROOM_W'(base + CAP * stride));           // miss after full scan
        push_item(CMD_READ, base, '0, '0, EIDX_W'(CAP - 1));
        push_item(CMD_DEL_INDEX, base, '0, '0, EIDX_W'(CAP - 1));      // last entry, no move
        push_rand(CMD_UPSERT, ROOM_W'(base + CAP * stride));           // append at the top
        push_item(CMD_DEL_INDEX, base, '0, '0, '0);                    // last moves to the front
        push_rand(CMD_DEL_ROOM, ROOM_W'(base + (CAP / 2) * stride));
        push_item(CMD_READ, base, '0, '0, '0);
        mixed_burst(20);
        push_rand(CMD_CLEAR, base);
    endtask

    // idle percentages per phase: sender light and receiver heavy, then swapped,
    // then no idling at all
    function automatic int idle_pct(input bit rcv_side);
        if (items_taken < n_total / 3) begin
            return rcv_side ? RECV_IDLE : SEND_IDLE;
        end
        if (items_taken < 2 * n_total / 3) begin
            return rcv_side ? SEND_IDLE : RECV_IDLE;
        end
        return 0;
    endfunction

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            err_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // driver: offers queued items, predicts each one as it is taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_proc
        t_result want;
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end else if (!drv_valid || o_ready) begin
            // the item on the bus, if any, is taken at this edge
            if (drv_valid) begin
                table_apply(cur_item, want);
                expected_q.push_back(want);
                items_taken <= items_taken + 1;
            end
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
                cur_item  <= pending_q.pop_front();
                drv_valid <= 1'b1;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off early on, so that a result sits unclaimed,
    // the next item gets taken and the block then stalls its input
    always @(posedge i_clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && items_taken >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // monitor: compares each taken result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : collect_proc
        t_result want;
        if (!rst_n) begin
            rcv_ready <= 1'b0;
        end else begin
            if (o_valid && rcv_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %h index %h used %h",
                             $time, o_status, o_found_index, o_used_entries);
                    err_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", 64'(want.status), 64'(o_status));
                    check_field("found_index", 64'(want.found_index), 64'(o_found_index));
                    check_field("out_room", 64'(want.data.room), 64'(o_out_room));
                    check_field("out_phone", 64'(want.data.phone), 64'(o_out_phone));
                    check_field("out_name_tag", want.data.name_tag, o_out_name_tag);
                    check_field("used_entries", 64'(want.used_entries), 64'(o_used_entries));
                end
            end
            rcv_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct(1'b1));
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stim_proc
        int kind;
        int fills_done;
        fills_done = 0;
        for (int k = 0; k < POOL_N; k++) begin
            room_pool[k] = ROOM_W'($urandom);
        end
        room_pool[0] = '0;
        room_pool[1] = '1;

        // directed: empty table, extremes, overwrite, both deletes, spares, clear
        push_item(CMD_LOOKUP, '0, '0, '0, '0);                         // empty table miss
        push_item(CMD_READ, '0, '0, '0, '0);                           // read past the count
        push_item(CMD_DEL_INDEX, '1, '1, '1, '1);                      // delete past the count
        push_item(CMD_DEL_ROOM, '1, '1, '1, '1);                       // delete absent room
        push_item(CMD_UPSERT, '0, '0, '0, '0);                         // append at 0
        push_item(CMD_UPSERT, '1, '1, '1, '1);                         // append at 1
        push_item(CMD_UPSERT, 16'h5a3c, 16'ha5c3, 64'h0123_4567_89ab_cdef, 8'h80);
        push_item(CMD_LOOKUP, '1, '0, '0, '0);                         // hit with all ones
        push_item(CMD_LOOKUP, '0, '1, '1, '1);                         // hit with all zeros
        push_item(CMD_UPSERT, '1, 16'h1234, 64'hfedc_ba98_7654_3210, '0); // overwrite
        push_item(CMD_READ, '0, '0, '0, 8'd1);
        push_item(CMD_READ, '0, '0, '0, 8'd3);                         // index equal to count
        push_item(CMD_SPARE_LO, '1, '1, '1, '1);
        push_item(CMD_SPARE_HI, '0, '0, '0, '0);
        push_item(CMD_DEL_ROOM, '0, '0, '0, '0);                       // hole filled from the end
        push_item(CMD_READ, '0, '0, '0, 8'd0);
        push_item(CMD_DEL_INDEX, '0, '0, '0, 8'd1);                    // last entry
        push_item(CMD_LOOKUP, 16'h5a3c, '0, '0, '0);
        push_item(CMD_DEL_INDEX, '0, '0, '0, 8'd0);                    // table empty again
        push_item(CMD_UPSERT, 16'h0001, 16'h8000, 64'h8000_0000_0000_0001, 8'h7f);
        push_item(CMD_UPSERT, 16'h8000, 16'h0001, 64'h0000_0001_8000_0000, 8'hfe);
        push_item(CMD_CLEAR, '0, '0, '0, '0);
        push_item(CMD_READ, '0, '0, '0, 8'd0);
        push_item(CMD_LOOKUP, 16'h0001, '0, '0, '0);

        // random part: mostly mixed traffic, a few builds, two fills to capacity
        while (n_items < TARGET_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (fills_done < 2 && n_items >= 400 + fills_done * 700) begin
                fill_burst();
                fills_done++;
            end else if (kind < 65) begin
                mixed_burst($urandom_range(10, 30));
            end else if (kind < 90) begin
                for (int k = $urandom_range(4, POOL_N); k > 0; k--) begin
                    push_rand(CMD_UPSERT, room_pool[$urandom_range(0, POOL_N - 1)]);
                end
                mixed_burst($urandom_range(10, 20));
            end else begin
                push_rand(CMD_CLEAR, pool_room());
                mixed_burst($urandom_range(5, 10));
            end
        end
        n_total = pending_q.size();

        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;

        while (items_taken != n_total) @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        // room for any stray result to show up
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("tb_keyed_compact_table: clean");
        end else begin
            $display("tb_keyed_compact_table: errors");
        end
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #(TIMEOUT_CYCLES * 20);
        $display("tb_keyed_compact_table: errors");
        $finish;
    end

endmodule
